FILE: rtl/bsm_pkg.sv
package bsm_pkg;

    localparam int BSM_COORD_WIDTH = 32;

    localparam logic [1:0] OUTC_KEPT     = 2'd0;
    localparam logic [1:0] OUTC_REPLACED = 2'd1;
    localparam logic [1:0] OUTC_GROWN    = 2'd2;
    localparam logic [1:0] OUTC_LOADED   = 2'd3;

    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_TAKE,
        CMD_DIFF,
        CMD_MUL_SQ,
        CMD_MUL_T,
        CMD_MUL_STEP,
        CMD_ACC,
        CMD_SQRT_INIT,
        CMD_SQRT_STEP,
        CMD_SQRT_FIX,
        CMD_GROW_PREP,
        CMD_DIV_INIT,
        CMD_DIV_STEP,
        CMD_COORD,
        CMD_COMMIT
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [1:0] idx;
        logic [1:0] outcome;
    } t_ctl;

    typedef struct packed {
        logic first;
        logic kept;
        logic replace;
    } t_sts;

endpackage

FILE: rtl/bsm_if.sv
interface bsm_in_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic                          first;
    logic signed [COORD_WIDTH-1:0] in_center_x;
    logic signed [COORD_WIDTH-1:0] in_center_y;
    logic signed [COORD_WIDTH-1:0] in_center_z;
    logic        [COORD_WIDTH-2:0] in_radius;

    modport source (output valid, first, in_center_x, in_center_y, in_center_z, in_radius,
                    input ready);
    modport sink   (input valid, first, in_center_x, in_center_y, in_center_z, in_radius,
                    output ready);
endinterface

interface bsm_out_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] out_center_x;
    logic signed [COORD_WIDTH-1:0] out_center_y;
    logic signed [COORD_WIDTH-1:0] out_center_z;
    logic        [COORD_WIDTH-2:0] out_radius;
    logic        [1:0]             outcome;

    modport source (output valid, out_center_x, out_center_y, out_center_z, out_radius,
                    outcome, input ready);
    modport sink   (input valid, out_center_x, out_center_y, out_center_z, out_radius,
                    outcome, output ready);
endinterface

FILE: rtl/bounding_sphere_merge.sv
// channel  dir  payload                                              beat when
// i_in     in   first, in_center_x/y/z, in_radius                    valid && ready
// o_out    out  out_center_x/y/z, out_radius, outcome                valid && ready
//
// one item at a time; a load goes via S_DIFF to S_COMMIT, which writes the result register
// a merge steps through the bit-serial multiplier and the square root, and when the sphere grows
// it also runs the bit-serial multiplier and the divider once per axis
// i_rst_n is synchronous, active low, and clears the kept sphere to center 0, radius 0
// a result waits in the output register; the next item is taken meanwhile and
// stalls only at its own commit until the previous result is taken
module bounding_sphere_merge
    import bsm_pkg::*;
#(
    parameter int COORD_WIDTH = BSM_COORD_WIDTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    bsm_in_if.sink          i_in,
    bsm_out_if.source       o_out
);

    t_ctl w_ctl;
    t_sts w_sts;

    bsm_ctrl #(.COORD_WIDTH(COORD_WIDTH)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_ctl       (w_ctl)
    );

    bsm_dp #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .o_sts      (w_sts),
        .i_first    (i_in.first),
        .i_center_x (i_in.in_center_x),
        .i_center_y (i_in.in_center_y),
        .i_center_z (i_in.in_center_z),
        .i_radius   (i_in.in_radius),
        .o_center_x (o_out.out_center_x),
        .o_center_y (o_out.out_center_y),
        .o_center_z (o_out.out_center_z),
        .o_radius   (o_out.out_radius),
        .o_outcome  (o_out.outcome)
    );

    a_take_is_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.cmd == CMD_TAKE) |-> (i_in.valid && i_in.ready))
        else $error("take without input beat");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken while busy");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.cmd == CMD_COMMIT) |=> o_out.valid)
        else $error("commit without output beat");

endmodule

FILE: rtl/bsm_ctrl.sv
module bsm_ctrl
    import bsm_pkg::*;
#(
    parameter int COORD_WIDTH = BSM_COORD_WIDTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_ctl o_ctl
);

    localparam int DW      = COORD_WIDTH + 2;
    localparam int QN      = COORD_WIDTH + 1;
    localparam int CNTW    = $clog2(DW);
    localparam logic [CNTW-1:0] MUL_LAST = CNTW'(DW - 1);
    localparam logic [CNTW-1:0] ITR_LAST = CNTW'(QN - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DIFF, S_SQ_INIT, S_SQ_RUN, S_ACC, S_SQRT_INIT, S_SQRT_RUN,
        S_SQRT_FIX, S_DECIDE, S_PREP, S_MT_INIT, S_MT_RUN, S_DIV_INIT,
        S_DIV_RUN, S_COORD, S_COMMIT
    } t_state;

    t_state          r_state;
    logic [CNTW-1:0] r_cnt;
    logic [1:0]      r_idx;
    logic [1:0]      r_outcome;
    logic            r_out_valid;
    logic            w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_ctl.cmd     = CMD_NOP;
        o_ctl.idx     = r_idx;
        o_ctl.outcome = r_outcome;
        unique case (r_state)
            S_IDLE:      if (i_in_valid) o_ctl.cmd = CMD_TAKE;
            S_DIFF:      if (!i_sts.first) o_ctl.cmd = CMD_DIFF;
            S_SQ_INIT:   o_ctl.cmd = CMD_MUL_SQ;
            S_SQ_RUN:    o_ctl.cmd = CMD_MUL_STEP;
            S_ACC:       o_ctl.cmd = CMD_ACC;
            S_SQRT_INIT: o_ctl.cmd = CMD_SQRT_INIT;
            S_SQRT_RUN:  o_ctl.cmd = CMD_SQRT_STEP;
            S_SQRT_FIX:  o_ctl.cmd = CMD_SQRT_FIX;
            S_DECIDE:    o_ctl.cmd = CMD_NOP;
            S_PREP:      o_ctl.cmd = CMD_GROW_PREP;
            S_MT_INIT:   o_ctl.cmd = CMD_MUL_T;
            S_MT_RUN:    o_ctl.cmd = CMD_MUL_STEP;
            S_DIV_INIT:  o_ctl.cmd = CMD_DIV_INIT;
            S_DIV_RUN:   o_ctl.cmd = CMD_DIV_STEP;
            S_COORD:     o_ctl.cmd = CMD_COORD;
            S_COMMIT:    if (w_out_free) o_ctl.cmd = CMD_COMMIT;
            default:     o_ctl.cmd = CMD_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_outcome   <= OUTC_KEPT;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_COMMIT && w_out_free) r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_idx <= '0;
                    if (i_sts.first) begin
                        r_outcome <= OUTC_LOADED;
                        r_state   <= S_COMMIT;
                    end else begin
                        r_state <= S_SQ_INIT;
                    end
                end
                S_SQ_INIT: begin
                    r_cnt   <= '0;
                    r_state <= S_SQ_RUN;
                end
                S_SQ_RUN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == MUL_LAST) r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_idx == 2'd2) begin
                        r_idx   <= '0;
                        r_state <= S_SQRT_INIT;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SQ_INIT;
                    end
                end
                S_SQRT_INIT: begin
                    r_cnt   <= '0;
                    r_state <= S_SQRT_RUN;
                end
                S_SQRT_RUN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == ITR_LAST) r_state <= S_SQRT_FIX;
                end
                S_SQRT_FIX: r_state <= S_DECIDE;
                S_DECIDE: begin
                    if (i_sts.kept) begin
                        r_outcome <= OUTC_KEPT;
                        r_state   <= S_COMMIT;
                    end else if (i_sts.replace) begin
                        r_outcome <= OUTC_REPLACED;
                        r_state   <= S_COMMIT;
                    end else begin
                        r_outcome <= OUTC_GROWN;
                        r_idx     <= '0;
                        r_state   <= S_PREP;
                    end
                end
                S_PREP: r_state <= S_MT_INIT;
                S_MT_INIT: begin
                    r_cnt   <= '0;
                    r_state <= S_MT_RUN;
                end
                S_MT_RUN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == MUL_LAST) r_state <= S_DIV_INIT;
                end
                S_DIV_INIT: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV_RUN;
                end
                S_DIV_RUN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == ITR_LAST) r_state <= S_COORD;
                end
                S_COORD: begin
                    if (r_idx == 2'd2) begin
                        r_state <= S_COMMIT;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_MT_INIT;
                    end
                end
                S_COMMIT: begin
                    if (w_out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/bsm_dp.sv
module bsm_dp
    import bsm_pkg::*;
#(
    parameter int COORD_WIDTH = BSM_COORD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_ctl                          i_ctl,
    output t_sts                          o_sts,
    input  logic                          i_first,
    input  logic signed [COORD_WIDTH-1:0] i_center_x,
    input  logic signed [COORD_WIDTH-1:0] i_center_y,
    input  logic signed [COORD_WIDTH-1:0] i_center_z,
    input  logic        [COORD_WIDTH-2:0] i_radius,
    output logic signed [COORD_WIDTH-1:0] o_center_x,
    output logic signed [COORD_WIDTH-1:0] o_center_y,
    output logic signed [COORD_WIDTH-1:0] o_center_z,
    output logic        [COORD_WIDTH-2:0] o_radius,
    output logic        [1:0]             o_outcome
);

    localparam int CW  = COORD_WIDTH;
    localparam int RW  = CW - 1;
    localparam int DLW = CW + 1;
    localparam int SW  = 2 * CW + 2;
    localparam int PW  = 2 * CW + 3;
    localparam int DW  = CW + 2;
    localparam int EW  = DW + 1;
    localparam int QN  = CW + 1;
    localparam int RMW = CW + 4;
    localparam logic [RW-1:0] RMAX = {RW{1'b1}};

    function automatic logic [DLW-1:0] mag(input logic signed [DLW-1:0] v);
        mag = v[DLW-1] ? DLW'(-v) : DLW'(v);
    endfunction

    logic                    r_first;
    logic signed [CW-1:0]    r_nc [3];
    logic        [RW-1:0]    r_nr;
    logic signed [CW-1:0]    r_cen [3];
    logic        [RW-1:0]    r_rad;
    logic signed [DLW-1:0]   r_dl [3];
    logic        [SW-1:0]    r_acc;
    logic        [PW-1:0]    r_mcand;
    logic        [DW-1:0]    r_mplier;
    logic        [PW-1:0]    r_prod;
    logic        [SW-1:0]    r_sq;
    logic        [RMW-1:0]   r_srem;
    logic        [QN-1:0]    r_root;
    logic        [DW-1:0]    r_d;
    logic        [DW-1:0]    r_big;
    logic        [DW-1:0]    r_t;
    logic        [QN-1:0]    r_num;
    logic        [DW-1:0]    r_drem;
    logic        [QN-1:0]    r_q;
    logic signed [CW-1:0]    r_ox, r_oy, r_oz;
    logic        [RW-1:0]    r_orad;
    logic        [1:0]       r_oout;

    logic        [DLW-1:0]   w_mag;
    logic        [RMW-1:0]   w_remx;
    logic        [RMW-1:0]   w_trial;
    logic                    w_sq_ge;
    logic        [DW:0]      w_dremx;
    logic                    w_div_ge;
    logic        [EW-1:0]    w_sum;
    logic        [DW-1:0]    w_big;
    logic        [PW-1:0]    w_n;
    logic signed [CW-1:0]    w_cen_n [3];
    logic        [RW-1:0]    w_rad_n;

    assign w_mag    = mag(r_dl[i_ctl.idx]);
    assign w_remx   = {r_srem[RMW-3:0], r_sq[SW-1:SW-2]};
    assign w_trial  = RMW'({r_root, 2'b01});
    assign w_sq_ge  = (w_remx >= w_trial);
    assign w_dremx  = {r_drem, r_num[QN-1]};
    assign w_div_ge = (w_dremx >= {1'b0, r_d});
    assign w_sum    = EW'(r_d) + EW'(r_nr) + EW'(r_rad) + EW'(1);
    assign w_big    = w_sum[EW-1:1];
    assign w_n      = r_prod + PW'(r_d >> 1);

    assign o_sts.first   = r_first;
    assign o_sts.kept    = (EW'(r_d) + EW'(r_nr)) <= EW'(r_rad);
    assign o_sts.replace = (EW'(r_d) + EW'(r_rad)) <= EW'(r_nr);

    always_comb begin
        for (int i = 0; i < 3; i++) w_cen_n[i] = r_cen[i];
        w_rad_n = r_rad;
        case (i_ctl.outcome)
            OUTC_LOADED, OUTC_REPLACED: begin
                for (int i = 0; i < 3; i++) w_cen_n[i] = r_nc[i];
                w_rad_n = r_nr;
            end
            OUTC_GROWN: w_rad_n = (r_big > DW'(RMAX)) ? RMAX : RW'(r_big);
            default:    w_rad_n = r_rad;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) r_cen[i] <= '0;
            r_rad   <= '0;
            r_first <= 1'b0;
        end else begin
            unique case (i_ctl.cmd)
                CMD_TAKE: begin
                    r_first <= i_first;
                    r_nc[0] <= i_center_x;
                    r_nc[1] <= i_center_y;
                    r_nc[2] <= i_center_z;
                    r_nr    <= i_radius;
                end
                CMD_DIFF: begin
                    for (int i = 0; i < 3; i++) r_dl[i] <= DLW'(r_nc[i]) - DLW'(r_cen[i]);
                    r_acc <= '0;
                end
                CMD_MUL_SQ: begin
                    r_mcand  <= PW'(w_mag);
                    r_mplier <= DW'(w_mag);
                    r_prod   <= '0;
                end
                CMD_MUL_T: begin
                    r_mcand  <= PW'(w_mag);
                    r_mplier <= r_t;
                    r_prod   <= '0;
                end
                CMD_MUL_STEP: begin
                    if (r_mplier[0]) r_prod <= r_prod + r_mcand;
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                end
                CMD_ACC: r_acc <= r_acc + r_prod[SW-1:0];
                CMD_SQRT_INIT: begin
                    r_sq   <= r_acc;
                    r_srem <= '0;
                    r_root <= '0;
                end
                CMD_SQRT_STEP: begin
                    r_sq <= r_sq << 2;
                    if (w_sq_ge) begin
                        r_srem <= w_remx - w_trial;
                        r_root <= {r_root[QN-2:0], 1'b1};
                    end else begin
                        r_srem <= w_remx;
                        r_root <= {r_root[QN-2:0], 1'b0};
                    end
                end
                CMD_SQRT_FIX: r_d <= DW'(r_root) + DW'(r_srem != '0);
                CMD_GROW_PREP: begin
                    r_big <= w_big;
                    r_t   <= w_big - DW'(r_rad);
                end
                CMD_DIV_INIT: begin
                    r_drem <= w_n[PW-1:QN];
                    r_num  <= w_n[QN-1:0];
                    r_q    <= '0;
                end
                CMD_DIV_STEP: begin
                    r_num <= r_num << 1;
                    if (w_div_ge) begin
                        r_drem <= DW'(w_dremx - {1'b0, r_d});
                        r_q    <= {r_q[QN-2:0], 1'b1};
                    end else begin
                        r_drem <= DW'(w_dremx);
                        r_q    <= {r_q[QN-2:0], 1'b0};
                    end
                end
                CMD_COORD: begin
                    if (r_dl[i_ctl.idx][DLW-1])
                        r_cen[i_ctl.idx] <= r_cen[i_ctl.idx] - CW'(r_q);
                    else
                        r_cen[i_ctl.idx] <= r_cen[i_ctl.idx] + CW'(r_q);
                end
                CMD_COMMIT: begin
                    for (int i = 0; i < 3; i++) r_cen[i] <= w_cen_n[i];
                    r_rad  <= w_rad_n;
                    r_ox   <= w_cen_n[0];
                    r_oy   <= w_cen_n[1];
                    r_oz   <= w_cen_n[2];
                    r_orad <= w_rad_n;
                    r_oout <= i_ctl.outcome;
                end
                default: r_first <= r_first;
            endcase
        end
    end

    assign o_center_x = r_ox;
    assign o_center_y = r_oy;
    assign o_center_z = r_oz;
    assign o_radius   = r_orad;
    assign o_outcome  = r_oout;

endmodule
